// ----- sv/ihex_pkg.sv -----
// shared types and constants for the intel hex record parser
// no dependencies; imported by every module of the block
package ihex_pkg;

	// result kinds on the output channel
	localparam logic [1:0] KIND_PROG = 2'd0;
	localparam logic [1:0] KIND_CFG  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_BASE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_SIZE    = 2'd2;

	// characters and record types
	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] TYPE_DATA    = 8'h00;
	localparam logic [7:0] TYPE_EXT_LIN = 8'h04;

	// character positions within a line (1 is the first length digit)
	localparam logic [9:0] POS_LEN_END    = 10'd2;
	localparam logic [9:0] POS_ADDR_END   = 10'd6;
	localparam logic [9:0] POS_TYPE_END   = 10'd8;
	localparam logic [9:0] POS_DATA_START = 10'd9;
	localparam logic [9:0] POS_EXT_END    = 10'd12;
	localparam logic [9:0] POS_MAX        = 10'd1023;

	// one decoded operation handed from the front to the back
	typedef struct packed {
		logic        err;
		logic        prog;
		logic        cfg;
		logic [31:0] prog_addr;
		logic [31:0] cfg_addr;
		logic [7:0]  data;
	} ihex_op_t;

endpackage

// ----- sv/intel_hex_record_parser_core.sv -----
// Intel HEX record parser, one ASCII character per transfer.
// Input channel: text_char with in_valid / in_stall. Output channel: result_kind,
// write_address, write_data, last_of_run with out_valid / out_stall.
// Configuration: cfg_write with cfg_index (0 flash limit, 1 window base,
// 2 window size) and cfg_data; written at any edge with cfg_write high.
// Throughput: one character per cycle while in_stall is low. A data byte routed to
// both program memory and the configuration window yields two results, a program
// write and then a config write, delivered in turn by the single output register.
// A character's operation is first written into the queue at its transfer and then
// loaded into the output register, where out_valid rises.
// The front decodes each character combinationally and pushes byte writes and the
// error into a QUEUE_DEPTH entry queue; in_stall is high only while it is full.
// When the receiver stalls, the output holds and the queue absorbs up to
// QUEUE_DEPTH operations before in_stall rises.
// After a format error is delivered the block produces nothing more until reset.
// Reset (arst_n low, asynchronous) clears parser state, config registers, the
// queue and the output valid flag; no clearing pass is needed.
module intel_hex_record_parser_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     text_char,
	input  logic                           cfg_write,
	input  logic [ihex_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     result_kind,
	output logic [31:0]                    write_address,
	output logic [7:0]                     write_data,
	output logic                           last_of_run
);
	import ihex_pkg::*;

	logic     accept;
	logic     push;
	logic     pop;
	logic     q_empty;
	logic     q_full;
	ihex_op_t push_op;
	ihex_op_t head_op;

	// input transfer whenever the queue has room
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	ihex_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_char (text_char),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_op   (push_op)
	);

	ihex_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.empty   (q_empty),
		.full    (q_full)
	);

	ihex_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_op       (head_op),
		.empty         (q_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.write_address (write_address),
		.write_data    (write_data),
		.last_of_run   (last_of_run)
	);

`ifndef NO_ASSERTIONS
	// queue never written while full
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_full)
		else $error("operation queue overflow");

	// error result is a lone, zeroed result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_ERR |->
			last_of_run && write_address == 32'd0 && write_data == 8'd0)
		else $error("malformed error result");

	// nothing follows a delivered error
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && result_kind == KIND_ERR |=> !out_valid)
		else $error("result after format error");

	// a program write without last is followed by its config write
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && result_kind == KIND_PROG && !last_of_run |=>
			out_valid && result_kind == KIND_CFG)
		else $error("missing config write after program write");
`endif

endmodule

// ----- sv/ihex_front.sv -----
// front end: character decode, record state, routing decision, config registers
// depends on ihex_pkg; pushes ihex_op_t items into the operation queue
module ihex_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [7:0]                     text_char,
	input  logic                           cfg_write,
	input  logic [ihex_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output logic                           push,
	output ihex_pkg::ihex_op_t             push_op
);
	import ihex_pkg::*;

	// hex digit decode: bit 4 flags a valid digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		return r;
	endfunction

	logic [23:0] flash_limit_q;
	logic [31:0] win_base_q;
	logic [7:0]  win_size_q;

	logic [9:0]  pos_q;
	logic [15:0] acc_q;
	logic [7:0]  len_q;
	logic [15:0] raddr_q;
	logic [7:0]  rtype_q;
	logic [15:0] upper_q;
	logic        to_prog_q;
	logic        to_cfg_q;
	logic        err_q;
	logic [31:0] run_q;

	logic [4:0]  hex;
	logic [15:0] acc_next;
	logic [9:0]  data_off;
	logic        in_field;
	logic        bad_start;
	logic        bad_digit;
	logic        is_body;
	logic        data_byte;
	logic [31:0] eff;
	logic [32:0] win_diff;
	logic        hit_prog;
	logic        hit_cfg;

	assign hex      = hex_decode(text_char);
	assign acc_next = {acc_q[11:0], hex[3:0]};
	assign data_off = pos_q - POS_DATA_START;
	assign eff      = {upper_q, raddr_q};
	assign win_diff = {1'b0, eff} - {1'b0, win_base_q};
	assign hit_prog = eff < {8'd0, flash_limit_q};
	assign hit_cfg  = !win_diff[32] && (win_diff[31:0] < {24'd0, win_size_q});

	// which characters belong to a decoded field
	always_comb begin
		priority if (pos_q <= POS_TYPE_END) in_field = 1'b1;
		else if (rtype_q == TYPE_DATA) in_field = data_off < {1'b0, len_q, 1'b0};
		else if (rtype_q == TYPE_EXT_LIN) in_field = pos_q <= POS_EXT_END;
		else in_field = 1'b0;
	end

	assign bad_start = !err_q && pos_q == 10'd0 && text_char != CHAR_COLON;
	assign is_body   = !err_q && pos_q != 10'd0 && text_char != CHAR_NEWLINE;
	assign bad_digit = is_body && in_field && !hex[4];
	assign data_byte = is_body && in_field && hex[4] && pos_q >= POS_DATA_START
		&& rtype_q == TYPE_DATA && !pos_q[0];

	// operation pushed into the queue
	always_comb begin
		push_op.err       = bad_start || bad_digit;
		push_op.prog      = to_prog_q;
		push_op.cfg       = to_cfg_q;
		push_op.prog_addr = run_q;
		push_op.cfg_addr  = run_q - win_base_q;
		push_op.data      = acc_next[7:0];
		if (push_op.err) begin
			push_op.prog = 1'b0;
			push_op.cfg  = 1'b0;
		end
	end
	assign push = accept && (bad_start || bad_digit || (data_byte && (to_prog_q || to_cfg_q)));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_limit_q <= '0;
			win_base_q    <= '0;
			win_size_q    <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_FLASH_LIMIT: flash_limit_q <= cfg_data[23:0];
				CFG_WIN_BASE:    win_base_q    <= cfg_data;
				CFG_WIN_SIZE:    win_size_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// record state update per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			acc_q     <= '0;
			len_q     <= '0;
			raddr_q   <= '0;
			rtype_q   <= '0;
			upper_q   <= '0;
			to_prog_q <= 1'b0;
			to_cfg_q  <= 1'b0;
			err_q     <= 1'b0;
			run_q     <= '0;
		end else if (accept && !err_q) begin
			if (pos_q == 10'd0) begin
				if (bad_start) begin
					err_q <= 1'b1;
				end else begin
					acc_q <= '0;
					pos_q <= 10'd1;
				end
			end else if (text_char == CHAR_NEWLINE) begin
				pos_q <= '0;
			end else if (bad_digit) begin
				err_q <= 1'b1;
			end else begin
				if (in_field) begin
					acc_q <= acc_next;
					if (pos_q == POS_LEN_END) begin
						len_q <= acc_next[7:0];
					end else if (pos_q == POS_ADDR_END) begin
						raddr_q <= acc_next;
					end else if (pos_q == POS_TYPE_END) begin
						rtype_q   <= acc_next[7:0];
						to_prog_q <= hit_prog;
						to_cfg_q  <= hit_cfg;
						run_q     <= eff;
					end else if (data_byte) begin
						run_q <= run_q + 32'd1;
					end else if (pos_q == POS_EXT_END && rtype_q == TYPE_EXT_LIN) begin
						upper_q <= acc_next;
					end
				end
				if (pos_q != POS_MAX) pos_q <= pos_q + 10'd1;
			end
		end
	end

endmodule

// ----- sv/ihex_fifo.sv -----
// short operation queue between the front and the back
// depends on ihex_pkg for the entry type
module ihex_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ihex_pkg::ihex_op_t push_op,
	input  logic               pop,
	output ihex_pkg::ihex_op_t head_op,
	output logic               empty,
	output logic               full
);
	import ihex_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ihex_op_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head_op = mem_q[rd_ptr_q];
	assign empty   = count_q == '0;
	assign full    = count_q == CW'(DEPTH);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_op;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- sv/ihex_back.sv -----
// back end: expands queued operations into results behind an output register
// depends on ihex_pkg; reads the head of the operation queue
module ihex_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ihex_pkg::ihex_op_t head_op,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         result_kind,
	output logic [31:0]        write_address,
	output logic [7:0]         write_data,
	output logic               last_of_run
);
	import ihex_pkg::*;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [31:0] addr_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic        cfg_pending_q;

	logic        load;
	logic [1:0]  kind_d;
	logic [31:0] addr_d;
	logic [7:0]  data_d;
	logic        last_d;
	logic        done_d;

	assign load = !out_valid_q || !out_stall;

	// pick the next result from the head operation
	always_comb begin
		data_d = head_op.data;
		priority if (head_op.err) begin
			kind_d = KIND_ERR;
			addr_d = '0;
			data_d = '0;
			last_d = 1'b1;
			done_d = 1'b1;
		end else if (!cfg_pending_q && head_op.prog) begin
			kind_d = KIND_PROG;
			addr_d = head_op.prog_addr;
			last_d = !head_op.cfg;
			done_d = !head_op.cfg;
		end else begin
			kind_d = KIND_CFG;
			addr_d = head_op.cfg_addr;
			last_d = 1'b1;
			done_d = 1'b1;
		end
	end

	assign pop = load && !empty && done_d;

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			cfg_pending_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) cfg_pending_q <= !done_d;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load && !empty) begin
			kind_q <= kind_d;
			addr_q <= addr_d;
			data_q <= data_d;
			last_q <= last_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign write_address = addr_q;
	assign write_data    = data_q;
	assign last_of_run   = last_q;

endmodule
